@@ design/tto_pkg.sv @@
// tensor transpose offset map: shared constants
// configuration register kinds, reset rank and fixed field widths; no dependencies
package tto_pkg;

  localparam int RANK_W  = 3;
  localparam int FIELD_W = 3;
  localparam int RANK_RESET = 4;

  typedef enum logic [1:0] {
    REG_RANK,
    REG_EXTENT,
    REG_ORDER,
    REG_NONE
  } reg_kind_t;

endpackage

@@ design/tto_shape.sv @@
// tensor transpose offset map: shape derivation from configuration
// forms input strides, output strides per input axis, element count check
// depends on tto_pkg
module tto_shape #(
  parameter int MAX_RANK    = 6,
  parameter int OFFSET_BITS = 24,
  parameter int EXTENT_BITS = 13
) (
  input  logic                                  clk,
  input  logic [tto_pkg::RANK_W-1:0]            rank,
  input  logic [MAX_RANK-1:0][EXTENT_BITS-1:0]  extent,
  input  logic [tto_pkg::FIELD_W*MAX_RANK-1:0]  axis_order,
  output logic [MAX_RANK-1:0][OFFSET_BITS:0]    in_stride,
  output logic [MAX_RANK-1:0][OFFSET_BITS:0]    ostr_in,
  output logic [OFFSET_BITS:0]                  count,
  output logic                                  shape_ok
);

  localparam int AXW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int PW  = OFFSET_BITS + 1 + EXTENT_BITS;
  localparam logic [PW-1:0] LIMIT = PW'(1) << OFFSET_BITS;

  logic [MAX_RANK-1:0][EXTENT_BITS-1:0] ext_eff;
  logic [MAX_RANK-1:0][EXTENT_BITS-1:0] oext;
  logic [MAX_RANK-1:0][AXW-1:0]         perm;
  logic [MAX_RANK-1:0][OFFSET_BITS:0]   out_stride;
  logic [MAX_RANK-1:0][OFFSET_BITS:0]   ostr_next;
  logic                                 perm_ok;
  logic                                 rank_ok;
  logic [PW-1:0]                        count_prod;

  function automatic logic [OFFSET_BITS:0] sat_mul(input logic [OFFSET_BITS:0] a,
                                                   input logic [EXTENT_BITS-1:0] b);
    logic [PW-1:0] p;
    p = PW'(a) * PW'(b);
    if (p > LIMIT) begin
      p = LIMIT + PW'(1);
    end
    return p[OFFSET_BITS:0];
  endfunction

  always_comb begin
    logic [tto_pkg::FIELD_W-1:0] f;
    logic [tto_pkg::FIELD_W-1:0] g;
    rank_ok = (rank != '0) && (int'(rank) <= MAX_RANK);
    perm_ok = 1'b1;
    for (int k = 0; k < MAX_RANK; k++) begin
      ext_eff[k] = (k < int'(rank)) ? extent[k] : EXTENT_BITS'(1);
      f = axis_order[k*tto_pkg::FIELD_W +: tto_pkg::FIELD_W];
      if ((k < int'(rank)) && (int'(f) < MAX_RANK)) begin
        perm[k] = f[AXW-1:0];
      end else begin
        perm[k] = AXW'(k);
      end
      if ((k < int'(rank)) && (int'(f) >= int'(rank))) begin
        perm_ok = 1'b0;
      end
      for (int m = 0; m < MAX_RANK; m++) begin
        g = axis_order[m*tto_pkg::FIELD_W +: tto_pkg::FIELD_W];
        if ((m > k) && (m < int'(rank)) && (f == g)) begin
          perm_ok = 1'b0;
        end
      end
    end
    for (int k = 0; k < MAX_RANK; k++) begin
      oext[k] = ext_eff[perm[k]];
    end
    for (int j = 0; j < MAX_RANK; j++) begin
      ostr_next[j] = '0;
      for (int k = 0; k < MAX_RANK; k++) begin
        if (int'(perm[k]) == j) begin
          ostr_next[j] = ostr_next[j] | out_stride[k];
        end
      end
    end
    count_prod = PW'(in_stride[0]) * PW'(ext_eff[0]);
  end

  always_ff @(posedge clk) begin
    in_stride[MAX_RANK-1]  <= (OFFSET_BITS+1)'(1);
    out_stride[MAX_RANK-1] <= (OFFSET_BITS+1)'(1);
    for (int i = 0; i < MAX_RANK - 1; i++) begin
      in_stride[i]  <= sat_mul(in_stride[i+1], ext_eff[i+1]);
      out_stride[i] <= sat_mul(out_stride[i+1], oext[i+1]);
    end
    ostr_in <= ostr_next;
    count   <= sat_mul(in_stride[0], ext_eff[0]);
    shape_ok <= rank_ok && perm_ok && (count_prod <= LIMIT);
  end

endmodule

@@ design/tto_cell.sv @@
// tensor transpose offset map: one restoring division cell
// takes one quotient bit of an axis index and adds its output stride share
// no dependencies on tto_pkg
module tto_cell #(
  parameter int OFFSET_BITS = 24,
  parameter int EXTENT_BITS = 13,
  parameter int SHIFT       = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_v,
  input  logic                   in_err,
  input  logic [OFFSET_BITS-1:0] in_rem,
  input  logic [OFFSET_BITS-1:0] in_acc,
  input  logic [OFFSET_BITS:0]   stride,
  input  logic [OFFSET_BITS:0]   ostr,
  output logic                   out_v,
  output logic                   out_err,
  output logic [OFFSET_BITS-1:0] out_rem,
  output logic [OFFSET_BITS-1:0] out_acc
);

  localparam int WW = OFFSET_BITS + 1 + EXTENT_BITS;

  logic [WW-1:0] dv;
  logic [WW-1:0] os_sh;
  logic          ge;

  always_comb begin
    dv    = WW'(stride) << SHIFT;
    os_sh = WW'(ostr) << SHIFT;
    ge    = WW'(in_rem) >= dv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_err <= in_err;
      out_rem <= ge ? (in_rem - dv[OFFSET_BITS-1:0]) : in_rem;
      out_acc <= ge ? (in_acc + os_sh[OFFSET_BITS-1:0]) : in_acc;
    end
  end

endmodule

@@ design/tensor_transpose_offset_map_top.sv @@
// tensor transpose offset map top level: config registers, entry stage, cell chain
// an accepted request passes the entry stage and then the cell chain to out_valid
// throughput one request per cycle outside settling; a result held at the output stalls the whole chain
// reset: rank 4, extents 1, identity axis order, pipeline empty
// after reset or a config write, requests wait for derived strides until the settle counter runs out
// depends on tto_pkg, tto_shape, tto_cell
module tensor_transpose_offset_map_top #(
  parameter int MAX_RANK    = 6,
  parameter int OFFSET_BITS = 24,
  parameter int EXTENT_BITS = 13
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OFFSET_BITS-1:0] in_offset,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OFFSET_BITS-1:0] out_offset,
  output logic                   range_error,
  input  logic                   cfg_we,
  input  logic [$clog2(MAX_RANK+2)-1:0] cfg_index,
  input  logic [((tto_pkg::FIELD_W*MAX_RANK > EXTENT_BITS) ?
                 tto_pkg::FIELD_W*MAX_RANK : EXTENT_BITS)-1:0] cfg_data
);

  localparam int OW = tto_pkg::FIELD_W * MAX_RANK;
  localparam int IW = $clog2(MAX_RANK + 2);
  localparam int NC = MAX_RANK * EXTENT_BITS;
  localparam int SETTLE = MAX_RANK + 3;
  localparam int SW = $clog2(SETTLE + 1);

  logic [tto_pkg::RANK_W-1:0]           rank;
  logic [MAX_RANK-1:0][EXTENT_BITS-1:0] extent;
  logic [OW-1:0]                        axis_order;
  logic [MAX_RANK-1:0][OFFSET_BITS:0]   in_stride;
  logic [MAX_RANK-1:0][OFFSET_BITS:0]   ostr_in;
  logic [OFFSET_BITS:0]                 count;
  logic                                 shape_ok;
  logic [SW-1:0]                        settle;
  logic                                 adv;
  tto_pkg::reg_kind_t                   kind;

  logic                          entry_v;
  logic                          entry_err;
  logic [OFFSET_BITS-1:0]        entry_rem;

  wire [NC:0]                    v;
  wire [NC:0]                    err;
  wire [NC:0][OFFSET_BITS-1:0]   rem;
  wire [NC:0][OFFSET_BITS-1:0]   acc;

  always_comb begin
    if (cfg_index == '0) begin
      kind = tto_pkg::REG_RANK;
    end else if (int'(cfg_index) <= MAX_RANK) begin
      kind = tto_pkg::REG_EXTENT;
    end else if (int'(cfg_index) == MAX_RANK + 1) begin
      kind = tto_pkg::REG_ORDER;
    end else begin
      kind = tto_pkg::REG_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= tto_pkg::RANK_W'(tto_pkg::RANK_RESET);
      for (int i = 0; i < MAX_RANK; i++) begin
        extent[i] <= EXTENT_BITS'(1);
        axis_order[i*tto_pkg::FIELD_W +: tto_pkg::FIELD_W] <= tto_pkg::FIELD_W'(i);
      end
      settle <= SW'(SETTLE);
    end else begin
      if (cfg_we) begin
        settle <= SW'(SETTLE);
        unique case (kind)
          tto_pkg::REG_RANK:   rank <= cfg_data[tto_pkg::RANK_W-1:0];
          tto_pkg::REG_EXTENT: extent[IW'(cfg_index - IW'(1))] <= cfg_data[EXTENT_BITS-1:0];
          tto_pkg::REG_ORDER:  axis_order <= cfg_data[OW-1:0];
          default: ;
        endcase
      end else if (settle != '0) begin
        settle <= settle - SW'(1);
      end
    end
  end

  tto_shape #(
    .MAX_RANK(MAX_RANK), .OFFSET_BITS(OFFSET_BITS), .EXTENT_BITS(EXTENT_BITS)
  ) u_shape (
    .clk(clk), .rank(rank), .extent(extent), .axis_order(axis_order),
    .in_stride(in_stride), .ostr_in(ostr_in), .count(count), .shape_ok(shape_ok)
  );

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && (settle == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_v <= 1'b0;
    end else if (adv) begin
      entry_v <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      entry_err <= !shape_ok || ((OFFSET_BITS+1)'(in_offset) >= count);
      entry_rem <= in_offset;
    end
  end

  assign v[0]   = entry_v;
  assign err[0] = entry_err;
  assign rem[0] = entry_rem;
  assign acc[0] = '0;

  for (genvar c = 0; c < NC; c++) begin : g_cell
    tto_cell #(
      .OFFSET_BITS(OFFSET_BITS), .EXTENT_BITS(EXTENT_BITS),
      .SHIFT(EXTENT_BITS - 1 - (c % EXTENT_BITS))
    ) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .in_v(v[c]), .in_err(err[c]), .in_rem(rem[c]), .in_acc(acc[c]),
      .stride(in_stride[c / EXTENT_BITS]), .ostr(ostr_in[c / EXTENT_BITS]),
      .out_v(v[c+1]), .out_err(err[c+1]), .out_rem(rem[c+1]), .out_acc(acc[c+1])
    );
  end

  assign out_valid   = v[NC];
  assign range_error = err[NC];
  assign out_offset  = err[NC] ? '0 : acc[NC];

endmodule
